@@ design/wbps_pkg.sv @@
package wbps_pkg;

  // fixed widths of the register and result fields
  localparam int unsigned PATTERN_WORD_W = 64;
  localparam int unsigned WILDCARD_W     = 16;
  localparam int unsigned LEN_W          = 5;
  localparam int unsigned CFG_INDEX_W    = 2;
  localparam int unsigned MATCH_OFFSET_W = 32;
  localparam int unsigned PAT_IDX_W      = 4;

  // parameter defaults
  localparam int unsigned DEF_MAX_PATTERN = 16;
  localparam int unsigned DEF_OFFSET_BITS = 32;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH       = 2'd3;

  // per-cell compare setup: the aligned pattern byte and whether it counts
  typedef struct packed {
    logic       care;
    logic [7:0] pat;
  } cell_cfg_t;

endpackage

@@ design/wbps_cell.sv @@
module wbps_cell
  import wbps_pkg::*;
(
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] byte_in,
  input  cell_cfg_t  cell_cfg,
  output logic [7:0] byte_r,
  output logic       ok
);

  // window byte, handed on to the next cell on every accepted transfer
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  // compare the byte that enters this cell against its pattern byte
  assign ok = !cell_cfg.care || (byte_in == cell_cfg.pat);

endmodule

@@ design/wildcard_byte_pattern_search.sv @@
// Wildcard byte pattern search.
// Bytes of a region arrive on the in_ channel (in_data_byte, in_final_byte
// marks the last byte). The pattern, its wildcard mask and its length are
// written through the cfg_ channel (index 0 pattern bytes 0-7, 1 bytes 8-15,
// 2 wildcard mask, 3 length); the user must write them only while no search
// is in flight, the block does not enforce it. cfg_ready is always high.
// A row of cells holds the most recent bytes; every cell compares the byte
// shifting into it against its aligned pattern byte, so all positions are
// checked in the cycle a byte is taken.
// One result per region on the out_ channel: out_found = 1 with the start
// offset at the first full match, or out_found = 0 with offset 0 when the
// final byte arrives without a match.
// Latency: the result is valid the cycle after the byte that causes it is
// transferred. Throughput: one byte per cycle, limited only by the single
// output register; while a result waits and out_ready is low, in_ready is
// low and no byte is taken.
// Reset (rst_n low, synchronous) restores the register defaults (length 1)
// and clears the byte counter, window fill, match flag and output valid.
// After the final byte the counter, fill and match flag clear; the
// configuration is kept. The byte counter saturates at its top value.
module wildcard_byte_pattern_search
  import wbps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = DEF_MAX_PATTERN,
  parameter int unsigned OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_final_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_found,
  output logic [MATCH_OFFSET_W-1:0] out_match_offset,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [PATTERN_WORD_W-1:0] cfg_data
);

  localparam int unsigned FILL_W = $clog2(MAX_PATTERN + 1);

  // configuration registers
  logic [PATTERN_WORD_W-1:0] pat_low_r;
  logic [PATTERN_WORD_W-1:0] pat_high_r;
  logic [WILDCARD_W-1:0]     wild_r;
  logic [LEN_W-1:0]          len_r;

  // region state
  logic [FILL_W-1:0]      fill_r, fill_nxt, fill_inc;
  logic [OFFSET_BITS-1:0] count_r, count_nxt;
  logic                   seen_r, seen_nxt;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_found_r, out_found_nxt;
  logic [MATCH_OFFSET_W-1:0] out_offset_r, out_offset_nxt;

  logic                          in_fire;
  logic [LEN_W-1:0]              len_eff;
  logic [2*PATTERN_WORD_W-1:0]   pattern_all;
  logic [7:0]                    cell_in [MAX_PATTERN];
  logic [7:0]                    win [MAX_PATTERN];
  cell_cfg_t                     cell_cfg [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]        cell_ok;
  logic                          hit;
  logic                          emit;
  logic [OFFSET_BITS-1:0]        back;
  logic [OFFSET_BITS-1:0]        start;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  // clamp the programmed length to 1..MAX_PATTERN
  always_comb begin
    if (len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_r > LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = len_r;
    end
  end

  assign pattern_all = {pat_high_r, pat_low_r};

  // row of window cells; cell k holds the byte taken k transfers ago
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [LEN_W-1:0]     j_full;
    logic [PAT_IDX_W-1:0] j;

    // cell k lines up with pattern byte len-1-k
    assign j_full = len_eff - LEN_W'(k) - LEN_W'(1);
    assign j      = j_full[PAT_IDX_W-1:0];
    assign cell_cfg[k].care = (LEN_W'(k) < len_eff) && !wild_r[j];
    assign cell_cfg[k].pat  = pattern_all[j*8 +: 8];

    if (k == 0) begin : g_head
      assign cell_in[k] = in_data_byte;
    end else begin : g_link
      assign cell_in[k] = win[k-1];
    end

    wbps_cell u_cell (
      .clk      (clk),
      .shift_en (in_fire),
      .byte_in  (cell_in[k]),
      .cell_cfg (cell_cfg[k]),
      .byte_r   (win[k]),
      .ok       (cell_ok[k])
    );
  end

  // match decision on the window including the incoming byte
  assign fill_inc = (fill_r == FILL_W'(MAX_PATTERN)) ? fill_r : fill_r + FILL_W'(1);
  assign hit      = !seen_r && (LEN_W'(fill_inc) >= len_eff) && (&cell_ok);
  assign emit     = hit || (in_final_byte && !seen_r);

  // start offset, floored at zero
  assign back  = OFFSET_BITS'(len_eff - LEN_W'(1));
  assign start = (count_r >= back) ? count_r - back : '0;

  // next state for region and output register
  always_comb begin
    fill_nxt       = fill_r;
    count_nxt      = count_r;
    seen_nxt       = seen_r;
    out_valid_nxt  = out_valid_r;
    out_found_nxt  = out_found_r;
    out_offset_nxt = out_offset_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      if (in_final_byte) begin
        fill_nxt  = '0;
        count_nxt = '0;
        seen_nxt  = 1'b0;
      end else begin
        fill_nxt  = fill_inc;
        count_nxt = (count_r != '1) ? count_r + OFFSET_BITS'(1) : count_r;
        seen_nxt  = seen_r || hit;
      end
      if (emit) begin
        out_valid_nxt  = 1'b1;
        out_found_nxt  = hit;
        out_offset_nxt = hit ? MATCH_OFFSET_W'(start) : '0;
      end
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r   <= '0;
      pat_high_r  <= '0;
      wild_r      <= '0;
      len_r       <= LEN_W'(1);
      fill_r      <= '0;
      count_r     <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PATTERN_LOW:  pat_low_r  <= cfg_data;
          REG_PATTERN_HIGH: pat_high_r <= cfg_data;
          REG_WILDCARD:     wild_r     <= cfg_data[WILDCARD_W-1:0];
          REG_LENGTH:       len_r      <= cfg_data[LEN_W-1:0];
        endcase
      end
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_found_r  <= out_found_nxt;
    out_offset_r <= out_offset_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_match_offset = out_offset_r;

  // region state is clear coming out of reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (fill_r == '0) && (count_r == '0) && !seen_r && !out_valid_r)
    else $error("region state not cleared by reset");

  // the final byte clears the region
  a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_final_byte |=> (fill_r == '0) && (count_r == '0) && !seen_r)
    else $error("region state not cleared after final byte");

  // a match before the final byte is recorded as seen and reported as found
  a_hit_seen: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && hit && !in_final_byte |=> seen_r && out_valid_r && out_found_r)
    else $error("match not recorded");

  // a not-found result carries offset zero
  a_miss_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> (out_offset_r == '0))
    else $error("not-found result with nonzero offset");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import wbps_pkg::*;

  localparam int unsigned WIN_DEPTH   = DEF_MAX_PATTERN;
  localparam int unsigned ITEM_TARGET = 1350;

  // one search outcome as it leaves the block
  typedef struct packed {
    logic                      found;
    logic [MATCH_OFFSET_W-1:0] offset;
  } scan_outcome_t;

  // one row of the directed stimulus: a register write or a byte transfer
  typedef struct {
    bit                        is_cfg;
    logic [CFG_INDEX_W-1:0]    index;
    logic [PATTERN_WORD_W-1:0] data;
    logic [7:0]                byte_val;
    bit                        last;
    bit                        typed;
    bit                        has_outcome;
    scan_outcome_t             outcome;
  } stim_row_t;

  // receiver stall styles
  typedef enum int {RX_OPEN, RX_RANDOM, RX_EVERY_THIRD, RX_TRICKLE} rx_mode_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [7:0]                in_data_byte = 8'h00;
  logic                      in_final_byte = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      out_found;
  logic [MATCH_OFFSET_W-1:0] out_match_offset;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_W-1:0]    cfg_index = REG_PATTERN_LOW;
  logic [PATTERN_WORD_W-1:0] cfg_data = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  wildcard_byte_pattern_search dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_final_byte    (in_final_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_match_offset (out_match_offset),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // shadow copy of the registers and the search state
  logic [PATTERN_WORD_W-1:0]  cfg_pat_lo;
  logic [PATTERN_WORD_W-1:0]  cfg_pat_hi;
  logic [WILDCARD_W-1:0]      cfg_wild;
  logic [LEN_W-1:0]           cfg_len;
  logic [7:0]                 win_bytes [WIN_DEPTH];
  logic [DEF_OFFSET_BITS-1:0] byte_cnt;
  bit                         hit_seen;
  int unsigned                win_fill;

  scan_outcome_t expected_outcomes [$];
  stim_row_t     directed_rows [$];
  scan_outcome_t oldest_outcome;

  int items_sent    = 0;
  int regions_done  = 0;
  int settings_used = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int burst_left    = 0;
  int stall_tick    = 0;
  rx_mode_t stall_mode = RX_OPEN;

  // length in use after clamping
  function automatic int unsigned active_len();
    int unsigned n;
    n = cfg_len;
    if (n == 0) n = 1;
    if (n > WIN_DEPTH) n = WIN_DEPTH;
    return n;
  endfunction

  function automatic logic [7:0] pattern_at(int unsigned j);
    logic [2*PATTERN_WORD_W-1:0] both;
    both = {cfg_pat_hi, cfg_pat_lo};
    return both[8*j +: 8];
  endfunction

  task automatic clear_region();
    foreach (win_bytes[k]) win_bytes[k] = 8'h00;
    byte_cnt = '0;
    hit_seen = 1'b0;
    win_fill = 0;
  endtask

  // advance the shadow search by one byte, report the outcome it causes
  task automatic predict_scan(input logic [7:0] b, input bit last, output bit produced,
                              output scan_outcome_t res);
    int unsigned                len;
    bit                         hit;
    logic [DEF_OFFSET_BITS-1:0] start_pos;
    len = active_len();
    produced = 1'b0;
    res = '0;
    for (int k = WIN_DEPTH - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
    win_bytes[0] = b;
    if (win_fill < WIN_DEPTH) win_fill++;
    hit = !hit_seen && (win_fill >= len);
    for (int unsigned j = 0; j < len; j++)
      if (!cfg_wild[j] && win_bytes[len-1-j] != pattern_at(j)) hit = 1'b0;
    if (hit) begin
      start_pos = (byte_cnt >= len - 1) ? byte_cnt - (len - 1) : '0;
      hit_seen = 1'b1;
      produced = 1'b1;
      res.found = 1'b1;
      res.offset = start_pos[MATCH_OFFSET_W-1:0];
    end
    if (byte_cnt != '1) byte_cnt++;
    if (last) begin
      // region ended without a hit: not-found outcome
      if (!hit_seen) begin
        produced = 1'b1;
        res = '0;
      end
      clear_region();
      regions_done++;
    end
  endtask

  // one byte transfer, with burst gaps in front of it
  task automatic send_byte(input logic [7:0] b, input bit last, input bit typed,
                           input bit has_typed, input scan_outcome_t typed_res);
    int            gap;
    bit            produced;
    scan_outcome_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_final_byte <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    predict_scan(b, last, produced, res);
    if (typed) begin
      if (has_typed) expected_outcomes = {expected_outcomes, typed_res};
    end else if (produced) begin
      expected_outcomes = {expected_outcomes, res};
    end
  endtask

  // register write transfer; valid is lowered by the caller
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [PATTERN_WORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PATTERN_LOW:  cfg_pat_lo = val;
      REG_PATTERN_HIGH: cfg_pat_hi = val;
      REG_WILDCARD:     cfg_wild = val[WILDCARD_W-1:0];
      REG_LENGTH:       cfg_len = val[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // stop sending, wait for every outcome, then let the last byte settle
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_cfg(input logic [CFG_INDEX_W-1:0] idx,
                         input logic [PATTERN_WORD_W-1:0] val);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.index = idx;
    row.data = val;
    directed_rows = {directed_rows, row};
  endtask

  task automatic add_byte(input logic [7:0] b, input bit last, input bit typed,
                          input bit has, input bit fnd, input int unsigned off);
    stim_row_t row;
    row = '{default: '0};
    row.byte_val = b;
    row.last = last;
    row.typed = typed;
    row.has_outcome = has;
    row.outcome.found = fnd;
    row.outcome.offset = off;
    directed_rows = {directed_rows, row};
  endtask

  // random settings with extremes mixed in; upper bits of length and mask data are junk
  task automatic pick_settings();
    logic [PATTERN_WORD_W-1:0] junk;
    logic [PATTERN_WORD_W-1:0] word;
    logic [WILDCARD_W-1:0]     mask;
    logic [LEN_W-1:0]          len_val;
    case ($urandom_range(0, 9))
      0: len_val = '0;
      1: len_val = LEN_W'(DEF_MAX_PATTERN);
      2: len_val = LEN_W'($urandom_range(DEF_MAX_PATTERN + 1, (1 << LEN_W) - 1));
      3: len_val = LEN_W'(1);
      default: len_val = LEN_W'($urandom_range(2, 8));
    endcase
    junk = {$urandom, $urandom};
    write_reg(REG_LENGTH, {junk[PATTERN_WORD_W-1:LEN_W], len_val});
    for (int w = 0; w < 2; w++) begin
      case ($urandom_range(0, 7))
        0: word = '0;
        1: word = '1;
        default: word = {$urandom, $urandom};
      endcase
      write_reg(w == 0 ? REG_PATTERN_LOW : REG_PATTERN_HIGH, word);
    end
    case ($urandom_range(0, 5))
      0: mask = '0;
      1: mask = '1;
      default: mask = WILDCARD_W'($urandom & $urandom);
    endcase
    junk = {$urandom, $urandom};
    write_reg(REG_WILDCARD, {junk[PATTERN_WORD_W-1:WILDCARD_W], mask});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // one region: mostly a planted copy of the pattern inside biased noise,
  // sometimes with one position broken, sometimes none at all
  task automatic scan_region();
    int unsigned len;
    int unsigned n;
    int unsigned plant_at;
    int unsigned wreck;
    int unsigned j;
    bit          plant;
    logic [7:0]  b;
    len = active_len();
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, len + 12);
    plant = (n >= len) && ($urandom_range(0, 4) != 0);
    plant_at = plant ? $urandom_range(0, n - len) : n;
    wreck = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : WIN_DEPTH;
    for (int unsigned i = 0; i < n; i++) begin
      if (plant && i >= plant_at && i < plant_at + len) begin
        j = i - plant_at;
        b = cfg_wild[j] ? 8'($urandom) : pattern_at(j);
        if (j == wreck) b = ~b;
      end else if ($urandom_range(0, 1) == 1) begin
        b = pattern_at($urandom_range(0, len - 1));
      end else begin
        b = 8'($urandom);
      end
      send_byte(b, i == n - 1, 1'b0, 1'b0, '0);
    end
  endtask

  task automatic note_mismatch(input string what, input scan_outcome_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): expected found=%0b offset=%0d, got found=%0b offset=%0d",
               what, want.found, want.offset, out_found, out_match_offset);
  endtask

  // receiver stalls, in a style that is picked at random and changed over the run
  always @(posedge clk) begin
    if (stall_tick == 0) begin
      stall_mode = rx_mode_t'($urandom_range(0, 3));
      stall_tick = $urandom_range(20, 80);
    end
    stall_tick--;
    case (stall_mode)
      RX_OPEN:        out_ready <= 1'b1;
      RX_RANDOM:      out_ready <= ($urandom_range(0, 3) != 0);
      RX_EVERY_THIRD: out_ready <= (stall_tick % 3 == 0);
      default:        out_ready <= (stall_tick % 8 == 7);
    endcase
  end

  // compare each outcome transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_outcomes.size() == 0) begin
        note_mismatch("no outcome pending", '0);
      end else begin
        oldest_outcome = expected_outcomes.pop_front();
        if (out_found !== oldest_outcome.found || out_match_offset !== oldest_outcome.offset)
          note_mismatch("field", oldest_outcome);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d outcomes pending", expected_outcomes.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    stim_row_t row;
    bit        prev_cfg;
    prev_cfg = 1'b0;
    cfg_pat_lo = '0;
    cfg_pat_hi = '0;
    cfg_wild = '0;
    cfg_len = LEN_W'(1);
    clear_region();

    // reset settings: one-byte pattern of zero
    add_byte(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 0);
    add_byte(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 0);
    add_byte(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 0);
    add_byte(8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 0);
    // zero length acts as one, wildcard bits past the length are ignored
    add_cfg(REG_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0);
    add_cfg(REG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFAB);
    add_cfg(REG_WILDCARD, 64'hFFFF_FFFF_FFFF_FFFE);
    add_byte(8'h12, 1'b0, 1'b1, 1'b0, 1'b0, 0);
    add_byte(8'hAB, 1'b1, 1'b1, 1'b1, 1'b1, 1);
    // oversized length clamps to the full window, every position wild
    add_cfg(REG_LENGTH, 64'd31);
    add_cfg(REG_WILDCARD, 64'hFFFF);
    add_cfg(REG_PATTERN_HIGH, '1);
    for (int i = 0; i < WIN_DEPTH; i++)
      add_byte(i[0] ? 8'hFF : 8'h00, i == WIN_DEPTH - 1, 1'b1, i == WIN_DEPTH - 1, 1'b1, 0);
    // two-byte pattern, later copies in the region are ignored
    add_cfg(REG_LENGTH, 64'd2);
    add_cfg(REG_WILDCARD, 64'h0);
    add_cfg(REG_PATTERN_LOW, 64'h5A3C);
    add_byte(8'h3C, 1'b0, 1'b0, 1'b0, 1'b0, 0);
    add_byte(8'h3C, 1'b0, 1'b0, 1'b0, 1'b0, 0);
    add_byte(8'h5A, 1'b0, 1'b0, 1'b0, 1'b0, 0);
    add_byte(8'h3C, 1'b0, 1'b0, 1'b0, 1'b0, 0);
    add_byte(8'h5A, 1'b1, 1'b0, 1'b0, 1'b0, 0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.is_cfg) begin
        if (!prev_cfg) drain();
        write_reg(row.index, row.data);
      end else begin
        if (prev_cfg) cfg_valid <= 1'b0;
        send_byte(row.byte_val, row.last, row.typed, row.has_outcome, row.outcome);
      end
      prev_cfg = row.is_cfg;
    end

    // random phases, settings change only with the block idle
    while (items_sent < ITEM_TARGET) begin
      drain();
      pick_settings();
      repeat ($urandom_range(3, 10)) scan_region();
    end
    drain();

    $display("scanned %0d bytes in %0d regions under %0d random settings",
             items_sent, regions_done, settings_used);
    $display("checked %0d outcomes, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
